FILE: rtl/csw_pkg.sv
package csw_pkg;

	// waiter list geometry
	localparam int WAITER_SLOTS = 16;
	localparam int IDX_W   = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
	localparam int TOTAL_W = $clog2(WAITER_SLOTS + 1);

	// payload widths
	localparam int ID_W      = 8;
	localparam int COUNT_W   = 8;
	localparam int OUTCOME_W = 3;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [COUNT_W-1:0] INIT_COUNT_RST = COUNT_W'(1);
	localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};

	// register index, taken from paddr[2]
	localparam logic REG_INITIAL_COUNT = 1'b0;

	// request commands
	localparam logic CMD_WAIT = 1'b0;
	localparam logic CMD_POST = 1'b1;

	typedef enum logic [OUTCOME_W-1:0] {
		OC_GRANTED  = 3'd0,
		OC_QUEUED   = 3'd1,
		OC_REJECTED = 3'd2,
		OC_WOKEN    = 3'd3,
		OC_POSTED   = 3'd4
	} outcome_t;

	// count reload from the register block
	typedef struct packed {
		logic               load;
		logic [COUNT_W-1:0] value;
	} cfg_load_t;

endpackage

FILE: rtl/csw_ram.sv
module csw_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/csw_apb.sv
module csw_apb import csw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_load_t          cfg_load
);

	logic [COUNT_W-1:0] initial_count_q;
	logic               wr_hit;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_INITIAL_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_count_q <= INIT_COUNT_RST;
		end else if (wr_hit) begin
			initial_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_INITIAL_COUNT: prdata = {{(PDATA_W-COUNT_W){1'b0}}, initial_count_q};
			default:           prdata = '0;
		endcase
	end

	// count reloads in the same edge as the register write
	assign cfg_load.load  = wr_hit;
	assign cfg_load.value = pwdata[COUNT_W-1:0];

endmodule

FILE: rtl/counting_semaphore_waiter_list_core.sv
// Counting semaphore with an ordered waiter list. A wait request takes one
// resource when the count is nonzero (granted); otherwise the requester id is
// appended to the list (queued), or refused when all WAITER_SLOTS entries are
// in use (rejected). A post request returns one resource (saturating at 255)
// and wakes every listed waiter: one woken result per waiter in list order,
// last set on the final one, after which the list is empty; with no waiters it
// gives a single posted result. Woken agents must send a new wait request.
// Writing initial_count (byte address 0) reloads the count at once and leaves
// the list alone. Timing: a wait request, or a post with an empty list, is
// answered straight into the result register, and the block takes the next
// request as soon as the result register is free. A post with waiters keeps
// the request side closed until the final woken result has left the read stage,
// because the waiter ids sit in a single-port-read RAM that is walked one entry
// per cycle while the result side takes them, with a registered read in front.
// Results leave through a registered valid/ready stage. No clearing pass is
// needed after reset: only entries below the fill count are ever read.
module counting_semaphore_waiter_list_core import csw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic                 command,
	input  logic [ID_W-1:0]      requester_id,
	// result channel
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic [OUTCOME_W-1:0] outcome,
	output logic [ID_W-1:0]      waiter_id,
	output logic                 last,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	localparam logic [TOTAL_W-1:0] SLOTS_T = TOTAL_W'(WAITER_SLOTS);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t              state_q;
	cfg_load_t           cfg_load;
	logic [COUNT_W-1:0]  count_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [TOTAL_W-1:0]  rd_cnt_q;

	// read stage in front of the result register
	logic                s1_valid_s1;
	logic                s1_last_s1;

	// result register
	logic                rsp_valid_q;
	outcome_t            outcome_q;
	logic [ID_W-1:0]     waiter_id_q;
	logic                last_q;

	logic                out_free;
	logic                accept;
	logic                ram_we;
	logic                ram_re;
	logic [ID_W-1:0]     ram_rdata;
	logic                s1_move;
	logic                issue;
	logic                rsp_load;

	csw_apb u_apb (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cfg_load (cfg_load)
	);

	// waiter ids, appended at the fill count, walked from entry zero on a post
	csw_ram #(
		.DEPTH (WAITER_SLOTS),
		.WIDTH (ID_W),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (total_q[IDX_W-1:0]),
		.wdata (requester_id),
		.re    (ram_re),
		.raddr (rd_cnt_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// result register is free when empty or draining this cycle
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE) && out_free;
	assign accept    = req_valid && req_ready;

	// append only on a wait that finds no resource and room in the list
	assign ram_we = accept && (command == CMD_WAIT) && (count_q == '0) && (total_q < SLOTS_T);

	// walk: hand a read result on when the output frees, issue the next read
	// when the read stage is empty or emptying
	assign s1_move = (state_q == ST_WALK) && s1_valid_s1 && out_free;
	assign issue   = (state_q == ST_WALK) && (rd_cnt_q < total_q) && (!s1_valid_s1 || out_free);
	assign ram_re  = issue;

	// a result enters the output register: any accepted request except a post
	// with waiters, whose woken results come from the walk instead
	assign rsp_load = (accept && !((command == CMD_POST) && (total_q != '0))) || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// resource count: reload from the register, take on a grant, give back on a post
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= INIT_COUNT_RST;
		end else if (cfg_load.load) begin
			count_q <= cfg_load.value;
		end else if (accept && (command == CMD_WAIT) && (count_q != '0)) begin
			count_q <= count_q - COUNT_W'(1);
		end else if (accept && (command == CMD_POST) && (count_q != COUNT_MAX)) begin
			count_q <= count_q + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			rd_cnt_q    <= '0;
			s1_valid_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (command == CMD_WAIT) begin
							if ((count_q == '0) && (total_q < SLOTS_T)) begin
								total_q <= total_q + TOTAL_W'(1);
							end
						end else begin
							if (total_q != '0) begin
								rd_cnt_q <= '0;
								state_q  <= ST_WALK;
							end
						end
					end
				end
				ST_WALK: begin
					if (issue) begin
						s1_valid_s1 <= 1'b1;
						s1_last_s1  <= (rd_cnt_q + TOTAL_W'(1)) == total_q;
						rd_cnt_q    <= rd_cnt_q + TOTAL_W'(1);
					end else if (s1_move) begin
						s1_valid_s1 <= 1'b0;
					end
					if (s1_move && s1_last_s1) begin
						total_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload, loaded from the request or from the read stage
	always_ff @(posedge clk) begin
		if (accept) begin
			waiter_id_q <= requester_id;
			last_q      <= 1'b1;
			if (command == CMD_WAIT) begin
				if (count_q != '0) begin
					outcome_q <= OC_GRANTED;
				end else if (total_q < SLOTS_T) begin
					outcome_q <= OC_QUEUED;
				end else begin
					outcome_q <= OC_REJECTED;
				end
			end else begin
				outcome_q <= OC_POSTED;
			end
		end else if (s1_move) begin
			outcome_q   <= OC_WOKEN;
			waiter_id_q <= ram_rdata;
			last_q      <= s1_last_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign outcome   = outcome_q;
	assign waiter_id = waiter_id_q;
	assign last      = last_q;

	// list never holds more than its slots
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= SLOTS_T)
		else $error("waiter total beyond list size");

	// appends happen only outside a walk
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE) && !s1_valid_s1)
		else $error("list append during walk");

	// the walk never reads past the fill count
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (rd_cnt_q <= total_q) && (total_q != '0))
		else $error("walk index out of range");

	// handing on the final woken waiter empties the list and ends the walk
	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && s1_last_s1) |=> (total_q == '0) && (state_q == ST_IDLE) && last_q)
		else $error("walk did not close on last waiter");

	// read stage is empty whenever requests are taken
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !s1_valid_s1)
		else $error("read stage busy while idle");

endmodule
